// ===== rtl/oec_pkg.sv =====
// Shared widths, types and codes for the overlap edge classifier.
package oec_pkg;

  localparam int LEN_BITS   = 20;
  localparam int DIFF_W     = LEN_BITS + 2;
  localparam int R_W        = LEN_BITS + 3;
  localparam int X_W        = LEN_BITS + 4;
  localparam int DIST_W     = LEN_BITS + 1;
  localparam int EXT_W      = 20;
  localparam int RATIO_W    = 17;
  localparam int RATIO_FRAC = 16;
  localparam int PR_W       = X_W + RATIO_W + 1;
  localparam int CP_W       = X_W + LEN_BITS + 1;
  localparam int CMP_W      = ((R_W > EXT_W + 1) ? R_W : EXT_W + 1) + 1;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_EXTENSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATIO_Q16 = 2'd1;

  localparam logic [EXT_W-1:0]   MIN_EXTENSION_RESET = 20'd50;
  localparam logic [RATIO_W-1:0] MIN_RATIO_RESET     = 17'd58982;

  localparam logic [KIND_W-1:0] KIND_DOVE_0      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DOVE_2      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DOVE_FLIP   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_A_CONTAINED = 3'd4;
  localparam logic [KIND_W-1:0] KIND_B_CONTAINED = 3'd5;
  localparam logic [KIND_W-1:0] KIND_INTERNAL    = 3'd6;

  typedef logic [LEN_BITS-1:0]      len_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [R_W-1:0]    r_t;
  typedef logic signed [X_W-1:0]    x_t;
  typedef logic signed [DIST_W-1:0] dist_t;
  typedef logic signed [PR_W-1:0]   pr_t;
  typedef logic signed [CP_W-1:0]   cp_t;
  typedef logic signed [CMP_W-1:0]  cmp_t;

  typedef struct packed {
    logic [EXT_W-1:0]   min_extension;
    logic [RATIO_W-1:0] min_ratio_q16;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    logic  fwd;
    r_t    r0;
    r_t    r1;
    x_t    x0;
    x_t    x1;
    diff_t a0;
    diff_t a1;
    len_t  la;
    len_t  lb;
  } geom_t;

endpackage

// ===== rtl/oec_cfg_regs.sv =====
// Configuration registers for the overlap edge classifier.
module oec_cfg_regs
  import oec_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  cfg_ready_o,
  output cfg_t                  cfg_o
);

  cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MIN_EXTENSION: cfg_d.min_extension = cfg_data_i[EXT_W-1:0];
        REG_MIN_RATIO_Q16: cfg_d.min_ratio_q16 = cfg_data_i[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_extension <= MIN_EXTENSION_RESET;
      cfg_q.min_ratio_q16 <= MIN_RATIO_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/oec_geom.sv =====
// Three pipeline stages that form overhangs, remaining and extended lengths.
module oec_geom
  import oec_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  len_t  len_a_i,
  input  len_t  start_a_i,
  input  len_t  end_a_i,
  input  len_t  len_b_i,
  input  len_t  start_b_i,
  input  len_t  end_b_i,
  output geom_t geom_o
);

  logic  s1_valid_q, s2_valid_q, s3_valid_q;
  logic  s1_fwd_d, s1_fwd_q, s2_fwd_q;
  diff_t la, sa, ea, lb, sb, eb;
  diff_t s1_head_a_d, s1_tail_a_d, s1_a0_d, s1_a1_d;
  diff_t s1_head_a_q, s1_tail_a_q, s1_head_b_q, s1_tail_b_q, s1_a0_q, s1_a1_q;
  diff_t s2_head_a_q, s2_tail_a_q, s2_head_b_q, s2_tail_b_q, s2_a0_q, s2_a1_q;
  len_t  s1_la_q, s1_lb_q, s2_la_q, s2_lb_q;
  r_t    s2_r0_d, s2_r1_d, s2_r0_q, s2_r1_q;
  r_t    sel0, sel1, el;
  geom_t s3_d, s3_q;

  assign la = $signed({2'b00, len_a_i});
  assign sa = $signed({2'b00, start_a_i});
  assign ea = $signed({2'b00, end_a_i});
  assign lb = $signed({2'b00, len_b_i});
  assign sb = $signed({2'b00, start_b_i});
  assign eb = $signed({2'b00, end_b_i});

  always_comb begin
    s1_fwd_d    = start_a_i < end_a_i;
    s1_head_a_d = s1_fwd_d ? sa : la - sa;
    s1_tail_a_d = s1_fwd_d ? la - ea : ea;
    s1_a0_d     = s1_fwd_d ? ea - sa : sa - ea;
    s1_a1_d     = eb - sb;
  end

  assign s2_r0_d = r_t'(s1_head_a_q) - r_t'(s1_head_b_q);
  assign s2_r1_d = r_t'(s1_tail_b_q) - r_t'(s1_tail_a_q);

  always_comb begin
    sel0 = s2_r0_q[R_W-1] ? r_t'(s2_head_a_q) : r_t'(s2_head_b_q);
    sel1 = s2_r1_q[R_W-1] ? r_t'(s2_tail_b_q) : r_t'(s2_tail_a_q);
    el   = sel0 + sel1;
    s3_d.valid = s2_valid_q;
    s3_d.fwd   = s2_fwd_q;
    s3_d.r0    = s2_r0_q;
    s3_d.r1    = s2_r1_q;
    s3_d.x0    = x_t'(s2_a0_q) + x_t'(el);
    s3_d.x1    = x_t'(s2_a1_q) + x_t'(el);
    s3_d.a0    = s2_a0_q;
    s3_d.a1    = s2_a1_q;
    s3_d.la    = s2_la_q;
    s3_d.lb    = s2_lb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_fwd_q    <= s1_fwd_d;
    s1_head_a_q <= s1_head_a_d;
    s1_tail_a_q <= s1_tail_a_d;
    s1_head_b_q <= sb;
    s1_tail_b_q <= lb - eb;
    s1_a0_q     <= s1_a0_d;
    s1_a1_q     <= s1_a1_d;
    s1_la_q     <= len_a_i;
    s1_lb_q     <= len_b_i;
    s2_fwd_q    <= s1_fwd_q;
    s2_head_a_q <= s1_head_a_q;
    s2_tail_a_q <= s1_tail_a_q;
    s2_head_b_q <= s1_head_b_q;
    s2_tail_b_q <= s1_tail_b_q;
    s2_a0_q     <= s1_a0_q;
    s2_a1_q     <= s1_a1_q;
    s2_la_q     <= s1_la_q;
    s2_lb_q     <= s1_lb_q;
    s2_r0_q     <= s2_r0_d;
    s2_r1_q     <= s2_r1_d;
    s3_q        <= s3_d;
  end

  always_comb begin
    geom_o       = s3_q;
    geom_o.valid = s3_valid_q;
  end

endmodule

// ===== rtl/oec_decide.sv =====
// Two pipeline stages for the ratio products, containment products and edge decision.
module oec_decide
  import oec_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  geom_t             geom_i,
  input  cfg_t              cfg_i,
  output logic              result_valid_o,
  output logic [KIND_W-1:0] edge_kind_o,
  output dist_t             dist_a_o,
  output dist_t             dist_b_o
);

  cmp_t  m, neg_m, r0c, r1c;
  r_t    nr0, nr1;
  pr_t   s4_prat0_d, s4_prat1_d, s4_a0_sh_d, s4_a1_sh_d;
  pr_t   s4_prat0_q, s4_prat1_q, s4_a0_sh_q, s4_a1_sh_q;
  cp_t   s4_pc0_d, s4_pc1_d, s4_pc0_q, s4_pc1_q;
  logic  s4_valid_q, s4_fwd_q, s4_neg_q, s4_dove_d, s4_dove_q;
  logic  s4_x0_pos_d, s4_x1_pos_d, s4_x0_pos_q, s4_x1_pos_q;
  dist_t s4_d0_d, s4_d1_d, s4_d0_q, s4_d1_q;
  logic  ok0, ok1;
  logic  [KIND_W-1:0] kind_base, kind_d, kind_q;
  dist_t dist_a_d, dist_b_d, dist_a_q, dist_b_q;
  logic  valid_q;

  always_comb begin
    m     = cmp_t'($signed({1'b0, cfg_i.min_extension}));
    neg_m = -m;
    r0c   = cmp_t'(geom_i.r0);
    r1c   = cmp_t'(geom_i.r1);
    nr0   = -geom_i.r0;
    nr1   = -geom_i.r1;
    s4_dove_d   = (r0c >= m && r1c >= m) || (r0c <= neg_m && r1c <= neg_m);
    s4_x0_pos_d = !geom_i.x0[X_W-1] && (geom_i.x0 != '0);
    s4_x1_pos_d = !geom_i.x1[X_W-1] && (geom_i.x1 != '0);
    s4_prat0_d  = pr_t'($signed({1'b0, cfg_i.min_ratio_q16})) * pr_t'(geom_i.x0);
    s4_prat1_d  = pr_t'($signed({1'b0, cfg_i.min_ratio_q16})) * pr_t'(geom_i.x1);
    s4_a0_sh_d  = pr_t'(geom_i.a0) <<< RATIO_FRAC;
    s4_a1_sh_d  = pr_t'(geom_i.a1) <<< RATIO_FRAC;
    s4_pc0_d    = cp_t'(geom_i.x0) * cp_t'($signed({1'b0, geom_i.lb}));
    s4_pc1_d    = cp_t'(geom_i.x1) * cp_t'($signed({1'b0, geom_i.la}));
    s4_d0_d     = geom_i.r0[R_W-1] ? nr1[DIST_W-1:0] : geom_i.r0[DIST_W-1:0];
    s4_d1_d     = geom_i.r0[R_W-1] ? nr0[DIST_W-1:0] : geom_i.r1[DIST_W-1:0];
  end

  always_comb begin
    ok0       = s4_x0_pos_q && (s4_a0_sh_q >= s4_prat0_q);
    ok1       = s4_x1_pos_q && (s4_a1_sh_q >= s4_prat1_q);
    kind_base = s4_fwd_q ? KIND_DOVE_0 : KIND_DOVE_2;
    dist_a_d  = '1;
    dist_b_d  = '1;
    priority if (!(ok0 && ok1)) begin
      kind_d = KIND_INTERNAL;
    end else if (s4_dove_q) begin
      kind_d   = s4_neg_q ? (kind_base ^ KIND_DOVE_FLIP) : kind_base;
      dist_a_d = s4_d0_q;
      dist_b_d = s4_d1_q;
    end else if (s4_pc0_q > s4_pc1_q) begin
      kind_d = KIND_A_CONTAINED;
    end else begin
      kind_d = KIND_B_CONTAINED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      s4_valid_q <= geom_i.valid;
      valid_q    <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_fwd_q    <= geom_i.fwd;
    s4_neg_q    <= geom_i.r0[R_W-1];
    s4_dove_q   <= s4_dove_d;
    s4_x0_pos_q <= s4_x0_pos_d;
    s4_x1_pos_q <= s4_x1_pos_d;
    s4_prat0_q  <= s4_prat0_d;
    s4_prat1_q  <= s4_prat1_d;
    s4_a0_sh_q  <= s4_a0_sh_d;
    s4_a1_sh_q  <= s4_a1_sh_d;
    s4_pc0_q    <= s4_pc0_d;
    s4_pc1_q    <= s4_pc1_d;
    s4_d0_q     <= s4_d0_d;
    s4_d1_q     <= s4_d1_d;
    kind_q      <= kind_d;
    dist_a_q    <= dist_a_d;
    dist_b_q    <= dist_b_d;
  end

  assign result_valid_o = valid_q;
  assign edge_kind_o    = kind_q;
  assign dist_a_o       = dist_a_q;
  assign dist_b_o       = dist_b_q;

endmodule

// ===== rtl/overlap_edge_classifier_top.sv =====
// Top level of the overlap edge classifier.
// The block takes one item per clock cycle and busy stays low. Each item
// runs through five register stages: three for the overhang and extended
// length arithmetic, one for the ratio and containment multipliers, and one
// for the final compare and output register. Its result appears on the
// result ports with result_valid_o high for one cycle, in acceptance order.
// The receiver cannot stall, and none is needed. Configuration writes are
// always ready; the registers feed the multiplier stage directly, so write
// them only while no item is in flight.
module overlap_edge_classifier_top
  import oec_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  len_t                  len_a_i,
  input  len_t                  start_a_i,
  input  len_t                  end_a_i,
  input  len_t                  len_b_i,
  input  len_t                  start_b_i,
  input  len_t                  end_b_i,
  output logic                  result_valid_o,
  output logic [KIND_W-1:0]     edge_kind_o,
  output dist_t                 dist_a_o,
  output dist_t                 dist_b_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic  accept;
  cfg_t  cfg;
  geom_t geom;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  oec_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  oec_geom u_geom (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .len_a_i   (len_a_i),
    .start_a_i (start_a_i),
    .end_a_i   (end_a_i),
    .len_b_i   (len_b_i),
    .start_b_i (start_b_i),
    .end_b_i   (end_b_i),
    .geom_o    (geom)
  );

  oec_decide u_decide (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .geom_i         (geom),
    .cfg_i          (cfg),
    .result_valid_o (result_valid_o),
    .edge_kind_o    (edge_kind_o),
    .dist_a_o       (dist_a_o),
    .dist_b_o       (dist_b_o)
  );

  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 result_valid_o)
    else $error("Accepted item produced no result after five cycles.");

  a_latency_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, 5))
    else $error("Result appeared without an item accepted five cycles earlier.");

  a_no_dist : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (edge_kind_o == KIND_A_CONTAINED ||
      edge_kind_o == KIND_B_CONTAINED || edge_kind_o == KIND_INTERNAL))
    |-> (dist_a_o == '1 && dist_b_o == '1))
    else $error("Non-dovetail result carries overhang distances.");

endmodule

// ===== bench/oec_result_checker.sv =====
// Checker that predicts each overlap classification and compares the results.
`timescale 1ns / 1ps
module oec_result_checker
  import oec_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  len_t                  len_a_i,
  input  len_t                  start_a_i,
  input  len_t                  end_a_i,
  input  len_t                  len_b_i,
  input  len_t                  start_b_i,
  input  len_t                  end_b_i,
  input  logic                  result_valid_i,
  input  logic [KIND_W-1:0]     edge_kind_i,
  input  dist_t                 dist_a_i,
  input  dist_t                 dist_b_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatch_count_o,
  output int                    results_owed_o
);

  localparam int PRINT_CAP = 50;

  typedef struct {
    logic [KIND_W-1:0] kind;
    dist_t             dist_a;
    dist_t             dist_b;
  } edge_result_t;

  edge_result_t       owed_results[$];
  logic [EXT_W-1:0]   min_extension;
  logic [RATIO_W-1:0] min_ratio;
  int                 mismatches = 0;
  int                 owed_count = 0;

  assign mismatch_count_o = mismatches;
  assign results_owed_o   = owed_count;

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  function automatic bit ratio_passes(longint aligned, longint extended, longint ratio);
    if (extended <= 0) begin
      return 1'b0;
    end
    return aligned * (longint'(1) << RATIO_FRAC) >= ratio * extended;
  endfunction

  function automatic edge_result_t classify_overlap(len_t la_v, len_t sa_v, len_t ea_v,
                                                    len_t lb_v, len_t sb_v, len_t eb_v,
                                                    logic [EXT_W-1:0] ext_v,
                                                    logic [RATIO_W-1:0] ratio_v);
    longint       la, sa, ea, lb, sb, eb, m, ratio;
    longint       head_a, tail_a, head_b, tail_b, a0, a1, r0, r1, el, x0, x1, d0, d1;
    bit           fwd;
    edge_result_t res;
    la = longint'(la_v);
    sa = longint'(sa_v);
    ea = longint'(ea_v);
    lb = longint'(lb_v);
    sb = longint'(sb_v);
    eb = longint'(eb_v);
    m = longint'(ext_v);
    ratio = longint'(ratio_v);
    fwd = sa < ea;
    head_a = fwd ? sa : la - sa;
    tail_a = fwd ? la - ea : ea;
    head_b = sb;
    tail_b = lb - eb;
    a0 = fwd ? ea - sa : sa - ea;
    a1 = eb - sb;
    r0 = head_a - head_b;
    r1 = tail_b - tail_a;
    el = ((r0 < 0) ? head_a : head_b) + ((r1 < 0) ? tail_b : tail_a);
    x0 = a0 + el;
    x1 = a1 + el;
    d0 = -1;
    d1 = -1;
    if (ratio_passes(a0, x0, ratio) && ratio_passes(a1, x1, ratio)) begin
      if ((r0 >= m && r1 >= m) || (r0 <= -m && r1 <= -m)) begin
        res.kind = fwd ? KIND_DOVE_0 : KIND_DOVE_2;
        if (r0 < 0) begin
          res.kind = res.kind ^ KIND_DOVE_FLIP;
          d0 = -r1;
          d1 = -r0;
        end else begin
          d0 = r0;
          d1 = r1;
        end
      end else if (x0 * lb > x1 * la) begin
        res.kind = KIND_A_CONTAINED;
      end else begin
        res.kind = KIND_B_CONTAINED;
      end
    end else begin
      res.kind = KIND_INTERNAL;
    end
    res.dist_a = d0[DIST_W-1:0];
    res.dist_b = d1[DIST_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    edge_result_t want;
    if (!rst_ni) begin
      owed_results.delete();
      min_extension = MIN_EXTENSION_RESET;
      min_ratio = MIN_RATIO_RESET;
      owed_count <= 0;
    end else begin
      if (result_valid_i) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result kind %0d arrived with no item outstanding",
                                    edge_kind_i));
        end else begin
          want = owed_results.pop_front();
          if (edge_kind_i !== want.kind) begin
            report_mismatch($sformatf("edge_kind got %0d, expected %0d",
                                      edge_kind_i, want.kind));
          end
          if (dist_a_i !== want.dist_a) begin
            report_mismatch($sformatf("dist_a got %0d, expected %0d",
                                      dist_a_i, want.dist_a));
          end
          if (dist_b_i !== want.dist_b) begin
            report_mismatch($sformatf("dist_b got %0d, expected %0d",
                                      dist_b_i, want.dist_b));
          end
        end
      end
      if (start_i && !busy_i) begin
        owed_results.push_back(classify_overlap(len_a_i, start_a_i, end_a_i,
                                                len_b_i, start_b_i, end_b_i,
                                                min_extension, min_ratio));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MIN_EXTENSION: begin
            min_extension = cfg_data_i[EXT_W-1:0];
          end
          REG_MIN_RATIO_Q16: begin
            min_ratio = cfg_data_i[RATIO_W-1:0];
          end
          default: begin
          end
        endcase
      end
      owed_count <= owed_results.size();
    end
  end

endmodule

// ===== bench/tb_overlap_edge_classifier_top.sv =====
// Testbench top that drives items and register writes into the overlap edge classifier.
`timescale 1ns / 1ps
module tb_overlap_edge_classifier_top;
  import oec_pkg::*;

  localparam int   CYCLE_LIMIT   = 200000;
  localparam int   SETTLE_CYCLES = 12;
  localparam len_t LEN_MAX       = '1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  len_t                  len_a_i;
  len_t                  start_a_i;
  len_t                  end_a_i;
  len_t                  len_b_i;
  len_t                  start_b_i;
  len_t                  end_b_i;
  logic                  result_valid_o;
  logic [KIND_W-1:0]     edge_kind_o;
  dist_t                 dist_a_o;
  dist_t                 dist_b_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int     mismatch_count;
  int     results_owed;
  int     cycle_count = 0;
  int     burst_left = 0;
  longint cur_min_ext;

  overlap_edge_classifier_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .len_a_i        (len_a_i),
    .start_a_i      (start_a_i),
    .end_a_i        (end_a_i),
    .len_b_i        (len_b_i),
    .start_b_i      (start_b_i),
    .end_b_i        (end_b_i),
    .result_valid_o (result_valid_o),
    .edge_kind_o    (edge_kind_o),
    .dist_a_o       (dist_a_o),
    .dist_b_o       (dist_b_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  oec_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .len_a_i          (len_a_i),
    .start_a_i        (start_a_i),
    .end_a_i          (end_a_i),
    .len_b_i          (len_b_i),
    .start_b_i        (start_b_i),
    .end_b_i          (end_b_i),
    .result_valid_i   (result_valid_o),
    .edge_kind_i      (edge_kind_o),
    .dist_a_i         (dist_a_o),
    .dist_b_i         (dist_b_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .results_owed_o   (results_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 45) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  function automatic longint pick_overhang();
    longint v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = 0;
      3, 4: v = longint'($urandom_range(0, 3));
      5, 6: begin
        v = cur_min_ext + longint'($urandom_range(0, 4)) - 2;
        if (v < 0) begin
          v = 0;
        end
      end
      7, 8: v = longint'($urandom_range(0, 2000));
      default: v = longint'($urandom_range(0, 20'hFFFFF));
    endcase
    return v;
  endfunction

  function automatic longint pick_aligned();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) begin
      return longint'($urandom_range(1, 5000));
    end
    if (roll < 19) begin
      return longint'($urandom_range(1, 200000));
    end
    return longint'($urandom_range(1, 20'hFFFFF));
  endfunction

  // Drives one item, holds it until accepted, then idles for a random gap, which can be zero.
  task automatic send_item(len_t la, len_t sa, len_t ea, len_t lb, len_t sb, len_t eb);
    int gap;
    start <= 1'b1;
    len_a_i <= la;
    start_a_i <= sa;
    end_a_i <= ea;
    len_b_i <= lb;
    start_b_i <= sb;
    end_b_i <= eb;
    do @(posedge clk_i); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Most items are laid out as real overlaps from random overhangs; the rest
  // are raw noise or overlaps with one field broken.
  task automatic send_random_item();
    int     roll;
    longint a0, a1, jit, ha, ta, hb, tb, la;
    len_t   f[6];
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      foreach (f[i]) begin
        f[i] = len_t'($urandom());
      end
    end else begin
      a0 = pick_aligned();
      jit = longint'($urandom_range(0, int'(a0 / 8) + 1));
      a1 = $urandom_range(0, 1) ? a0 + jit : a0 - jit;
      if (a1 < 1) begin
        a1 = 1;
      end
      ha = pick_overhang();
      ta = pick_overhang();
      hb = pick_overhang();
      tb = pick_overhang();
      la = ha + a0 + ta;
      f[0] = len_t'(la);
      if ($urandom_range(0, 1)) begin
        f[1] = len_t'(ha);
        f[2] = len_t'(ha + a0);
      end else begin
        f[1] = len_t'(a0 + ta);
        f[2] = len_t'(ta);
      end
      f[3] = len_t'(hb + a1 + tb);
      f[4] = len_t'(hb);
      f[5] = len_t'(hb + a1);
      if (roll < 22) begin
        f[$urandom_range(0, 5)] = len_t'($urandom());
      end
    end
    send_item(f[0], f[1], f[2], f[3], f[4], f[5]);
  endtask

  task automatic send_random_items(int count);
    repeat (count) send_random_item();
  endtask

  // Waits until every result owed has come back, with start low.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_MIN_EXTENSION) begin
      cur_min_ext = longint'(value);
    end
    @(posedge clk_i);
  endtask

  task automatic send_directed_items();
    send_item(1000, 500, 1000, 1000, 0, 500);
    send_item(1000, 0, 500, 1000, 500, 1000);
    send_item(1000, 500, 0, 1000, 0, 500);
    send_item(1000, 1000, 500, 1000, 500, 1000);
    send_item(500, 0, 500, 2000, 700, 1200);
    send_item(2000, 700, 1200, 500, 0, 500);
    send_item(1000, 0, 500, 1000, 100, 400);
    send_item(1000, 0, 1000, 1000, 0, 1000);
    send_item(65536, 0, 58982, 65536, 0, 58982);
    send_item(65536, 0, 58981, 65536, 0, 58981);
    send_item(0, 0, 0, 0, 0, 0);
    send_item(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX);
    send_item(LEN_MAX, 0, LEN_MAX, LEN_MAX, 0, LEN_MAX);
    send_item(LEN_MAX, LEN_MAX, 0, LEN_MAX, 0, LEN_MAX);
    send_item(1, 0, 1, 1, 0, 1);
    send_item(0, 0, 1000, 0, 0, 1000);
    send_item(100, 50, 900, 100, 0, 800);
    send_item(1000, 500, 1000, 1000, 600, 100);
    send_item(1000, 550, 1000, 1000, 500, 950);
    send_item(1000, 549, 1000, 1000, 500, 951);
  endtask

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    len_a_i <= '0;
    start_a_i <= '0;
    end_a_i <= '0;
    len_b_i <= '0;
    start_b_i <= '0;
    end_b_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_MIN_EXTENSION;
    cfg_data_i <= '0;
    cur_min_ext = longint'(MIN_EXTENSION_RESET);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_directed_items();
    send_random_items(150);
    drain();

    // With no extension threshold, zero overhangs count as a dovetail.
    write_reg(REG_MIN_EXTENSION, '0);
    write_reg(REG_MIN_RATIO_Q16, '0);
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom()));
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom()));
    send_item(1000, 0, 1000, 1000, 0, 1000);
    send_item(1000, 1000, 0, 1000, 0, 1000);
    send_random_items(150);
    drain();

    write_reg(REG_MIN_EXTENSION, LEN_MAX);
    write_reg(REG_MIN_RATIO_Q16, 65536);
    send_random_items(150);
    drain();

    write_reg(REG_MIN_EXTENSION, CFG_DATA_W'($urandom_range(0, 200)));
    write_reg(REG_MIN_RATIO_Q16, CFG_DATA_W'($urandom_range(40000, 65536)));
    send_random_items(150);
    drain();

    write_reg(REG_MIN_EXTENSION, CFG_DATA_W'($urandom()));
    write_reg(REG_MIN_RATIO_Q16, CFG_DATA_W'($urandom_range(0, 65536)));
    send_random_items(100);
    drain();

    write_reg(REG_MIN_EXTENSION, CFG_DATA_W'($urandom_range(0, 100)));
    write_reg(REG_MIN_RATIO_Q16, 32768);
    send_random_items(150);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/oec_pkg.sv
rtl/oec_cfg_regs.sv
rtl/oec_geom.sv
rtl/oec_decide.sv
rtl/overlap_edge_classifier_top.sv
bench/oec_result_checker.sv
bench/tb_overlap_edge_classifier_top.sv
